[hdl/cle_pkg.sv]
// Shared types and constants for the cursor list engine.
// Holds the action codes, the per-cell command type and the default sizes.
// No dependencies.
package cle_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int WIDTH_DEF  = 32;
    // Cells combined by one first-level node of the read tree
    localparam int READ_GROUP = 8;

    typedef enum logic [3:0] {
        ACT_APPEND = 4'd0,
        ACT_INSERT = 4'd1,
        ACT_REMOVE = 4'd2,
        ACT_NEXT   = 4'd3,
        ACT_PREV   = 4'd4,
        ACT_START  = 4'd5,
        ACT_END    = 4'd6,
        ACT_MOVE   = 4'd7,
        ACT_CLEAR  = 4'd8,
        ACT_READ   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      sel;
    } cell_ctl_t;

endpackage

[hdl/cle_cell.sv]
// One storage cell of the list chain: holds one element.
// Loads new data or takes a neighbor's word; drives its word when selected.
// Depends on cle_pkg.
module cle_cell
    import cle_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [WIDTH-1:0] din,
    input  logic [WIDTH-1:0] left,
    input  logic [WIDTH-1:0] right,
    output logic [WIDTH-1:0] q,
    output logic [WIDTH-1:0] rd
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // Pick the next word for this cell
    always_comb
    begin
        case (ctl.cmd)
            CELL_LOAD:       data_next = din;
            CELL_FROM_LEFT:  data_next = left;
            CELL_FROM_RIGHT: data_next = right;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q  = data_reg;
    assign rd = ctl.sel ? data_reg : '0;

endmodule

[hdl/cle_read_tree.sv]
// Registered OR tree that gathers the selected cell's word.
// First level registers groups of READ_GROUP cells; second level is combinational.
// Depends on cle_pkg.
module cle_read_tree
    import cle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] word [DEPTH],
    output logic [WIDTH-1:0] merged
);

    localparam int NG = (DEPTH + READ_GROUP - 1) / READ_GROUP;

    logic [WIDTH-1:0] grp_reg [NG];
    logic [WIDTH-1:0] grp_next [NG];

    // Combine each group of cells
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < READ_GROUP; k++)
            begin
                if (g * READ_GROUP + k < DEPTH)
                begin
                    grp_next[g] = grp_next[g] | word[g * READ_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    // Merge the group results
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NG; g++)
        begin
            merged = merged | grp_reg[g];
        end
    end

endmodule

[hdl/cursor_list_engine_unit.sv]
// Cursor list engine: ordered list held in a chain of cells, with a cursor.
// Top level; uses cle_pkg, cle_cell and cle_read_tree.
//
// Usage:
//   Input stream (s_axis_*): one transfer carries one action with its element
//   and position. Output stream (m_axis_*): one transfer per action with the
//   length, the cursor, the element at the cursor, its valid flag and the
//   overflow flag.
//   The list update happens at the input transfer, in the same cycle for all
//   cells: an append loads the cell at the length, an insert loads the cursor
//   cell and shifts the cells past it, a remove shifts the cells at or past
//   the cursor. The element at the cursor is read through a two-level OR
//   tree, its first level registered. One action is in flight at a time:
//   new input waits until the previous result has left the read stage.
//   The output register frees the input side: the next action is accepted
//   while a finished result still waits on m_axis_tready. A stalled receiver
//   holds the following result in the read stage and blocks further input.
//   Reset empties the list and puts the cursor at zero; element contents are
//   left undefined, since no entry is read before it is written.
//   An append or insert on a full list is dropped and flags overflow.
module cursor_list_engine_unit
    import cle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] action, [35:4] element, [44:36] position, [47:45] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [8:0] list_length, [17:9] cursor, [49:18] current_value,
    // [50] value_valid, [51] overflow, [55:52] zero
    output logic [55:0] m_axis_tdata
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = (CW > 9) ? CW : 9;
    localparam int EXW = (WIDTH > 32) ? WIDTH : 32;

    logic          accept;
    action_t       act;
    logic [EXW-1:0] elem_x;
    logic [WIDTH-1:0] elem_w;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] cursor_x;
    logic          full;
    logic          has_cur;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] cursor_next;
    logic          ovf_next;

    logic          p1_reg;
    logic          p2_reg;
    logic          ovf1_reg;
    logic          ovf2_reg;
    logic          out_free;
    logic          out_load;
    logic          out_valid_reg;
    logic [55:0]   out_data_reg;

    logic [WIDTH-1:0] cell_q  [DEPTH];
    logic [WIDTH-1:0] cell_rd [DEPTH];
    cell_ctl_t        cell_ctl [DEPTH];
    logic [WIDTH-1:0] merged;
    logic [EXW-1:0]   merged_x;

    // Decode the input transfer
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign act      = action_t'(s_axis_tdata[3:0]);
    assign elem_x   = EXW'(s_axis_tdata[35:4]);
    assign elem_w   = elem_x[WIDTH-1:0];
    assign pos_x    = XW'(s_axis_tdata[44:36]);
    assign count_x  = XW'(count_reg);
    assign cursor_x = XW'(cursor_reg);
    assign full     = (count_reg == CW'(DEPTH));
    assign has_cur  = (cursor_reg < count_reg);

    // Next length, cursor and overflow flag
    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ovf_next    = 1'b0;
        case (act)
            ACT_APPEND, ACT_INSERT:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (has_cur)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_NEXT:
            begin
                if (has_cur)
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            ACT_PREV:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - 1'b1;
                end
            end
            ACT_START:
            begin
                cursor_next = '0;
            end
            ACT_END:
            begin
                cursor_next = count_reg;
            end
            ACT_MOVE:
            begin
                if (pos_x <= count_x)
                begin
                    cursor_next = pos_x[CW-1:0];
                end
            end
            ACT_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
            end
            default:
            begin
                count_next  = count_reg;
            end
        endcase
    end

    // Cell chain: per-cell command from its place against cursor and length
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        always_comb
        begin
            cell_ctl[i].sel = (cursor_reg == CW'(i));
            cell_ctl[i].cmd = CELL_HOLD;
            if (accept)
            begin
                case (act)
                    ACT_APPEND:
                    begin
                        if (!full && count_reg == CW'(i))
                        begin
                            cell_ctl[i].cmd = CELL_LOAD;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (!full)
                        begin
                            if (cursor_reg == CW'(i))
                            begin
                                cell_ctl[i].cmd = CELL_LOAD;
                            end
                            else if (CW'(i) > cursor_reg && CW'(i) <= count_reg)
                            begin
                                cell_ctl[i].cmd = CELL_FROM_LEFT;
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (has_cur && CW'(i) >= cursor_reg && i < DEPTH - 1)
                        begin
                            cell_ctl[i].cmd = CELL_FROM_RIGHT;
                        end
                    end
                    default:
                    begin
                        cell_ctl[i].cmd = CELL_HOLD;
                    end
                endcase
            end
        end

        cle_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk   (clk),
            .ctl   (cell_ctl[i]),
            .din   (elem_w),
            .left  (left_w),
            .right (right_w),
            .q     (cell_q[i]),
            .rd    (cell_rd[i])
        );
    end

    // Gather the word under the cursor
    cle_read_tree #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_read_tree (
        .clk    (clk),
        .word   (cell_rd),
        .merged (merged)
    );

    assign merged_x = EXW'(merged);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = p2_reg && out_free;

    // Hold list state and advance the read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            ovf1_reg      <= 1'b0;
            ovf2_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                ovf1_reg   <= ovf_next;
            end
            p1_reg <= accept;
            if (p1_reg)
            begin
                p2_reg   <= 1'b1;
                ovf2_reg <= ovf1_reg;
            end
            else if (out_load)
            begin
                p2_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {4'b0000, ovf2_reg, has_cur,
                             has_cur ? merged_x[31:0] : 32'd0,
                             cursor_x[8:0], count_x[8:0]};
        end
    end

    assign s_axis_tready = !p1_reg && !p2_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/cle_chk.sv]
// Port-level checker for the cursor list engine, bound to the top level.
// Watches both stream channels; no package needed.
module cle_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // A waiting input transfer holds its action
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input transfer changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer changed while stalled");

    // Cursor never passes the length
    a_cursor_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:9] <= m_axis_tdata[8:0])
        else $error("cursor beyond list length");

    // Valid flag agrees with cursor and length
    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[50] == (m_axis_tdata[17:9] < m_axis_tdata[8:0]))
        else $error("value_valid inconsistent with cursor and length");

    // No current element reads as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[50] |-> m_axis_tdata[49:18] == 32'd0)
        else $error("current_value not zero without a current element");

endmodule

bind cursor_list_engine_unit cle_chk u_cle_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
